>>> rtl/ics_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ics_pkg;

  localparam int VAL_W = 32;
  localparam int INV_W = 11;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic [INV_W-1:0]        inversions;
    logic                    last_out;
  } out_item_t;

  // per-cycle command broadcast along the cell row
  typedef struct packed {
    logic ins;   // insert new value, larger entries move right
    logic shl;   // shift whole row left by one (emit)
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/ics_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ics_cell
  import ics_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cell_ctrl_t              ctrl,
  input  wire logic signed [VAL_W-1:0] new_value,
  input  wire logic                    prev_gt,
  input  wire logic signed [VAL_W-1:0] left_value,
  input  wire logic                    left_valid,
  input  wire logic signed [VAL_W-1:0] right_value,
  input  wire logic                    right_valid,
  output logic signed [VAL_W-1:0]      value,
  output logic                         valid,
  output logic                         gt
);

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    valid_r, valid_nxt;

  // empty cells count as greater, so the insertion point is the first gt cell
  always_comb begin
    gt = !valid_r || (value_r > new_value);
  end

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctrl.ins) begin
      if (gt && prev_gt) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else if (gt) begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.shl) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else begin
      // idle: hold
      value_nxt = value_r;
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule
`default_nettype wire

>>> rtl/inversion_count_sorter.sv
// Inversion-counting sorter.
// Input channel (in_valid / in_stall / in_item): a sequence of signed 32-bit
// values, one per item, the final one flagged by last_in. Each value is
// written into a row of compare-and-shift cells as it is accepted, and the row
// takes the next value without waiting while loading; the inversion total
// grows by the number of stored values strictly greater than the new one.
// If an item arrives while MAX_ELEMS values are held, that item is dropped
// and the stored set is closed as if the previous item had been last.
// Result channel (out_valid / out_stall / out_item): once closed, the set
// leaves in ascending order, one item per cycle unless out_stall holds it,
// through an output register fed by the head cell while the row shifts left.
// Each item carries the sequence's inversion total; last_out marks the final
// one. The first result is shown once the state register has turned to emit
// and the head cell has been loaded into the output register.
// in_stall is high while a set is being emitted. A stall on the output
// holds the register and freezes the row; nothing is lost.
// Reset empties every cell and clears the counters and out_valid.
`timescale 1ns / 1ps
`default_nettype none
module inversion_count_sorter
  import ics_pkg::*;
#(
  parameter int MAX_ELEMS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int CNT_W = $clog2(MAX_ELEMS + 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;   // values held in the row
  logic [CNT_W-1:0] remain_r, remain_nxt; // values still to emit
  logic [INV_W-1:0] inv_r, inv_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;

  logic             in_acc;
  logic             full;
  logic             insert;
  logic             close;
  logic             out_load;
  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] pos;

  logic signed [VAL_W-1:0] cell_value [MAX_ELEMS];
  logic                    cell_valid [MAX_ELEMS];
  logic                    cell_gt    [MAX_ELEMS];
  logic                    prev_gt    [MAX_ELEMS];
  logic signed [VAL_W-1:0] left_value [MAX_ELEMS];
  logic                    left_valid [MAX_ELEMS];
  logic signed [VAL_W-1:0] right_value[MAX_ELEMS];
  logic                    right_valid[MAX_ELEMS];

  // ---- cell row ---------------------------------------------------------
  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_gt[i]    = 1'b0;
      assign left_value[i] = '0;
      assign left_valid[i] = 1'b0;
    end else begin : g_body
      assign prev_gt[i]    = cell_gt[i-1];
      assign left_value[i] = cell_value[i-1];
      assign left_valid[i] = cell_valid[i-1];
    end
    if (i == MAX_ELEMS - 1) begin : g_tail
      assign right_value[i] = '0;
      assign right_valid[i] = 1'b0;
    end else begin : g_mid
      assign right_value[i] = cell_value[i+1];
      assign right_valid[i] = cell_valid[i+1];
    end

    ics_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_value   (in_item.value),
      .prev_gt     (prev_gt[i]),
      .left_value  (left_value[i]),
      .left_valid  (left_valid[i]),
      .right_value (right_value[i]),
      .right_valid (right_valid[i]),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // Insertion point: the gt flags form a thermometer; encode its edge.
  // Values before it are <= new value, so the greater ones number count - pos.
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      if (cell_gt[i] && !prev_gt[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
  end

  // ---- handshake decode -------------------------------------------------
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(MAX_ELEMS));
  assign insert   = in_acc && !full;
  assign close    = in_acc && (full || in_item.last_in);
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // ---- next state -------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (close) state_nxt = ST_EMIT;
      ST_EMIT: if (out_load && remain_r == CNT_W'(1)) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // ---- outputs of the sequencer -----------------------------------------
  always_comb begin
    in_stall = 1'b1;
    ctrl     = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        ctrl.ins = insert;
      end
      ST_EMIT: begin
        ctrl.shl = out_load;
      end
      default: ;
    endcase
  end

  // ---- counters ---------------------------------------------------------
  always_comb begin
    count_nxt  = count_r;
    inv_nxt    = inv_r;
    remain_nxt = remain_r;
    if (insert) begin
      count_nxt = count_r + CNT_W'(1);
      inv_nxt   = inv_r + INV_W'(count_r - pos);
    end
    if (close) begin
      remain_nxt = count_nxt;
    end
    if (out_load) begin
      remain_nxt = remain_r - CNT_W'(1);
      if (remain_r == CNT_W'(1)) begin
        count_nxt = '0;
        inv_nxt   = '0;
      end
    end
  end

  // output register: drains whenever the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.sorted_value <= cell_value[0];
      out_item_r.inversions   <= inv_r;
      out_item_r.last_out     <= (remain_r == CNT_W'(1));
    end
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      remain_r    <= '0;
      inv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      inv_r       <= inv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> rtl/ics_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ics_checker
  import ics_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  logic                    out_acc;
  logic                    mid_r;
  logic signed [VAL_W-1:0] prev_val_r;
  logic [INV_W-1:0]        prev_inv_r;

  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_val_r <= out_item.sorted_value;
      prev_inv_r <= out_item.inversions;
    end
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (out_acc) begin
      mid_r <= !out_item.last_out;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // results of one set come out ascending with one inversion total
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && mid_r |->
      (out_item.sorted_value >= prev_val_r) && (out_item.inversions == prev_inv_r))
    else $error("result order or inversion total broken");

  // no loading while a set is still being emitted
  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_out |-> in_stall)
    else $error("input taken mid-emit");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled input item holds
  a_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

endmodule

bind inversion_count_sorter ics_checker u_ics_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire

>>> tb/sv/inversion_count_checker.sv
`timescale 1ns / 1ps
module inversion_count_checker
  import ics_pkg::*;
#(
  parameter int MAX_ELEMS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        errors,
  output int        pending
);

  // values of the open sequence, in arrival order
  logic signed [VAL_W-1:0] held_vals [MAX_ELEMS];
  int                      held_cnt;
  logic [INV_W-1:0]        inv_total;
  out_item_t               sorted_q [$];

  // stable insertion sort of the held set; queue one result per value
  task automatic emit_sorted();
    logic signed [VAL_W-1:0] ord [MAX_ELEMS];
    logic signed [VAL_W-1:0] x;
    int k;
    out_item_t r;
    for (int i = 0; i < held_cnt; i++) begin
      x = held_vals[i];
      k = i;
      while (k > 0 && $signed(ord[k-1]) > $signed(x)) begin
        ord[k] = ord[k-1];
        k--;
      end
      ord[k] = x;
    end
    for (int i = 0; i < held_cnt; i++) begin
      r.sorted_value = ord[i];
      r.inversions   = inv_total;
      r.last_out     = (i == held_cnt - 1);
      sorted_q.push_back(r);
    end
    held_cnt  = 0;
    inv_total = '0;
  endtask

  task automatic take_value(input in_item_t it);
    bit close_now;
    if (held_cnt >= MAX_ELEMS) begin
      // store full: item dropped, set closes as it stands
      close_now = 1'b1;
    end else begin
      for (int i = 0; i < held_cnt; i++)
        if ($signed(held_vals[i]) > $signed(it.value)) inv_total++;
      held_vals[held_cnt] = it.value;
      held_cnt++;
      close_now = it.last_in;
    end
    if (close_now) emit_sorted();
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (sorted_q.size() == 0) begin
      $error("unexpected item: sorted_value %0d inversions %0d last_out %0d",
             got.sorted_value, got.inversions, got.last_out);
      errors++;
    end else begin
      want = sorted_q.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        $error("sorted_value: expected %0d, actual %0d", want.sorted_value, got.sorted_value);
        errors++;
      end
      if (got.inversions !== want.inversions) begin
        $error("inversions: expected %0d, actual %0d", want.inversions, got.inversions);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0d, actual %0d", want.last_out, got.last_out);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_cnt  = 0;
      inv_total = '0;
      sorted_q.delete();
      errors    = 0;
    end else begin
      if (in_valid && !in_stall) take_value(in_item);
      if (out_valid && !out_stall) check_result(out_item);
    end
    pending = sorted_q.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the inversion-counting sorter. The checker beside
// the block watches both channels, predicts every sorted item and compares;
// this module only makes traffic and reads the failure count at the end.
module tb;
  import ics_pkg::*;

  localparam int MAX_ELEMS  = 64;
  localparam int RAND_ITEMS = 50;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        errors;
  int        pending;
  // calm stretches: no sender gaps and no output stalls
  bit        calm      = 1'b0;
  int        rand_items;
  int        set_len;

  always #5 clk = ~clk;

  inversion_count_sorter #(.MAX_ELEMS(MAX_ELEMS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  inversion_count_checker #(.MAX_ELEMS(MAX_ELEMS)) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .errors    (errors),
    .pending   (pending)
  );

  // Idle lengths: mostly from the shortest band, which includes none at all, now
  // and then a middle band, rarely one long enough to back the sorter up a while.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // Values lean towards small numbers so that duplicates (not inversions)
  // turn up often; extremes and full-width random patterns fill the rest.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return int'($urandom_range(0, 8)) - 4;
    else if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  // Present one item, hold it until taken, then maybe idle. The valid stays
  // high straight into the next item when no gap is drawn.
  task automatic send(input logic signed [VAL_W-1:0] v, input logic last);
    in_item_t it;
    int g;
    it.value   = v;
    it.last_in = last;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (!calm) begin
      g = idle_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  // Sender holds off until every predicted item has come out. Sampled on the
  // falling edge so the checker's update at the rising edge has settled.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // One sequence of n random values. With overfill the store is filled and
  // one more item is sent; it is dropped and closes the set, whatever its
  // last flag says.
  task automatic send_set(input int n, input bit overfill);
    for (int i = 0; i < n; i++) send(pick_value(), (i == n - 1) && !overfill);
    if (overfill) send(pick_value(), $urandom_range(0, 1));
  endtask

  // Output stall: runs of readiness and stall of random length; none at all
  // while calm. Every assignment is sampled at a clock edge before the next.
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b1;
        repeat (idle_len() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed sequences ---
    // single values at both ends of the range
    send(32'sh8000_0000, 1'b1);
    send(32'sh7FFF_FFFF, 1'b1);
    // extremes in reverse order, with a repeated minimum: equal pair not counted
    send(32'sh7FFF_FFFF, 1'b0);
    send(32'sh0000_0000, 1'b0);
    send(-32'sd1, 1'b0);
    send(32'sh8000_0000, 1'b0);
    send(32'sh8000_0000, 1'b1);
    // already ascending, no inversions
    send(32'sd1, 1'b0);
    send(32'sd2, 1'b0);
    send(32'sd3, 1'b1);
    // all equal
    repeat (3) send(32'sd5, 1'b0);
    send(32'sd5, 1'b1);
    // alternating bit patterns, sign bit set on the first
    send(32'shAAAA_AAAA, 1'b0);
    send(32'sh5555_5555, 1'b0);
    send(32'shAAAA_AAAA, 1'b1);
    drain();

    // strictly descending full store, largest inversion total, then a
    // dropped item that closes it
    for (int i = 0; i < MAX_ELEMS; i++) send(32'sd63 - i, 1'b0);
    send(32'sh7FFF_FFFF, 1'b1);
    drain();

    // --- random sequences ---
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      calm <= ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0: set_len = MAX_ELEMS;
        1, 2, 3: set_len = $urandom_range(9, 30);
        default: set_len = $urandom_range(1, 8);
      endcase
      send_set(set_len, (set_len == MAX_ELEMS) && $urandom_range(0, 1));
      rand_items += set_len;
      if ($urandom_range(0, 9) == 0) drain();
    end

    // --- wind-down ---
    drain();
    calm <= 1'b0;
    // run on to catch stray items after the last sequence
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** inversion_count_sorter: PASSED **");
    end else begin
      $display("** inversion_count_sorter: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("** inversion_count_sorter: FAILED **");
    $finish;
  end

endmodule
